// File: rtl/pow2ap_pkg.sv
// ----------------------------------------------------------------------------
// pow2ap_pkg
// Shared widths, reset constants and structs for the power-of-two atlas packer.
// ----------------------------------------------------------------------------
package pow2ap_pkg;

    localparam int unsigned SIZE_W = 4;
    localparam int unsigned OFS_W  = 15;
    localparam int unsigned LIDX_W = 16;
    localparam int unsigned FREE_W = 31;

    // Layer size exponent after reset; previous size also starts here
    localparam logic [SIZE_W-1:0] LAYER_LOG2_RST = 4'd7;

    typedef struct packed {
        logic [SIZE_W-1:0] size_log2;
        logic              first_item;
    } t_item;

    typedef struct packed {
        logic [OFS_W-1:0]  offset_x;
        logic [OFS_W-1:0]  offset_y;
        logic [LIDX_W-1:0] layer_index;
        logic              size_error;
    } t_result;

    typedef struct packed {
        logic [FREE_W-1:0] free_slots;
        logic [SIZE_W-1:0] prev_log2;
    } t_pack_state;

endpackage

// File: rtl/pow2ap_in_reg.sv
// ----------------------------------------------------------------------------
// pow2ap_in_reg
// Input register stage: captures one item and holds it until the next stage
// takes it.
// ----------------------------------------------------------------------------
module pow2ap_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pow2ap_pkg::t_item  i_item,
    input  logic               i_take,
    output logic               o_valid,
    output pow2ap_pkg::t_item  o_item
);
    import pow2ap_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_load;

    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/pow2ap_place.sv
// ----------------------------------------------------------------------------
// pow2ap_place
// Placement logic: free count update, slot index, Morton de-interleave and
// scaling for one texture.
// ----------------------------------------------------------------------------
module pow2ap_place #(
    parameter int unsigned MAX_LAYER_LOG2    = 15,
    parameter int unsigned LAYER_INDEX_WIDTH = 16
) (
    input  logic [pow2ap_pkg::SIZE_W-1:0] i_layer_log2,
    input  pow2ap_pkg::t_item             i_item,
    input  pow2ap_pkg::t_pack_state       i_state,
    input  logic [LAYER_INDEX_WIDTH-1:0]  i_layer,
    output pow2ap_pkg::t_result           o_result,
    output pow2ap_pkg::t_pack_state       o_state,
    output logic [LAYER_INDEX_WIDTH-1:0]  o_layer,
    output logic                          o_ok
);
    import pow2ap_pkg::*;

    localparam int unsigned SLOT_W = 2 * MAX_LAYER_LOG2;

    always_comb begin
        logic [SIZE_W-1:0]            l_eff;
        logic [SIZE_W-1:0]            s;
        logic [LAYER_INDEX_WIDTH-1:0] layer;
        logic [FREE_W-1:0]            freec;
        logic [SIZE_W-1:0]            prev;
        logic                         err;
        logic [SIZE_W-1:0]            drop;
        logic [SIZE_W-1:0]            depth;
        logic [FREE_W-1:0]            fshift;
        logic [FREE_W-1:0]            fneg;
        logic [SLOT_W-1:0]            mask;
        logic [SLOT_W-1:0]            slot;
        logic [MAX_LAYER_LOG2-1:0]    xd;
        logic [MAX_LAYER_LOG2-1:0]    yd;
        logic [31:0]                  lext;

        l_eff = (i_layer_log2 > SIZE_W'(MAX_LAYER_LOG2)) ? SIZE_W'(MAX_LAYER_LOG2)
                                                         : i_layer_log2;
        s     = i_item.size_log2;
        layer = i_layer;
        freec = i_state.free_slots;
        prev  = i_state.prev_log2;

        // batch start: layer 0, one whole free layer
        if (i_item.first_item) begin
            layer = '0;
            freec = FREE_W'(1);
            prev  = l_eff;
        end
        // full layer: advance, saturating at the top index
        if (freec == '0) begin
            if (!(&layer)) begin
                layer = layer + 1'b1;
            end
            freec = FREE_W'(1);
            prev  = l_eff;
        end

        err    = (s > prev) || (s > l_eff);
        drop   = prev - s;
        fshift = freec << {drop, 1'b0};
        depth  = l_eff - s;
        mask   = SLOT_W'((32'd1 << {depth, 1'b0}) - 32'd1);
        fneg   = (~fshift) + FREE_W'(1);
        slot   = fneg[SLOT_W-1:0] & mask;

        for (int j = 0; j < MAX_LAYER_LOG2; j++) begin
            xd[j] = slot[2*j];
            yd[j] = slot[2*j+1];
        end

        lext = 32'(layer);

        o_result.offset_x    = OFS_W'(xd) << s;
        o_result.offset_y    = OFS_W'(yd) << s;
        o_result.layer_index = lext[LIDX_W-1:0];
        o_result.size_error  = 1'b0;
        if (err) begin
            o_result = '0;
            o_result.size_error = 1'b1;
        end

        o_state.free_slots = fshift - FREE_W'(1);
        o_state.prev_log2  = s;
        o_layer            = layer;
        o_ok               = !err;
    end

endmodule

// File: rtl/pow2_atlas_array_packer.sv
// ----------------------------------------------------------------------------
// pow2_atlas_array_packer
// Packs square power-of-two textures into an array of square layers.
// ----------------------------------------------------------------------------
// Path: input transfer into the input register, then the result register;
//   placement runs between them.
// Throughput: 1 item per cycle while not stalled, set by the state update loop.
// Reset (synchronous, active low): layer 0, one free slot, previous size 7,
//   layer size exponent 7, both pipeline stages empty.
// ----------------------------------------------------------------------------
module pow2_atlas_array_packer #(
    parameter int unsigned MAX_LAYER_LOG2    = 15,
    parameter int unsigned LAYER_INDEX_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pow2ap_pkg::SIZE_W-1:0] i_size_log2,
    input  logic                          i_first_item,
    // result output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pow2ap_pkg::OFS_W-1:0]  o_offset_x,
    output logic [pow2ap_pkg::OFS_W-1:0]  o_offset_y,
    output logic [pow2ap_pkg::LIDX_W-1:0] o_layer_index,
    output logic                          o_size_error,
    // configuration write channel: layer_size_log2
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pow2ap_pkg::SIZE_W-1:0] i_cfg_data
);
    import pow2ap_pkg::*;

    t_item                        w_in_item;
    t_item                        w_item;
    logic                         w_item_valid;
    logic                         w_move;
    t_result                      w_result;
    t_pack_state                  w_state_nxt;
    logic [LAYER_INDEX_WIDTH-1:0] w_layer_nxt;
    logic                         w_ok;

    logic [SIZE_W-1:0]            r_cfg_log2;
    t_pack_state                  r_state;
    logic [LAYER_INDEX_WIDTH-1:0] r_layer;
    logic                         r_out_valid;
    logic                         n_out_valid;
    t_result                      r_result;

    // Configuration: always ready; write only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_log2 <= LAYER_LOG2_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg_log2 <= i_cfg_data;
        end
    end

    assign w_in_item.size_log2  = i_size_log2;
    assign w_in_item.first_item = i_first_item;

    // Input stage
    pow2ap_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (w_in_item),
        .i_take  (w_move),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    // Advance the held item whenever the result register is free or draining
    assign w_move = w_item_valid && (!r_out_valid || !i_stall);

    pow2ap_place #(
        .MAX_LAYER_LOG2    (MAX_LAYER_LOG2),
        .LAYER_INDEX_WIDTH (LAYER_INDEX_WIDTH)
    ) u_place (
        .i_layer_log2 (r_cfg_log2),
        .i_item       (w_item),
        .i_state      (r_state),
        .i_layer      (r_layer),
        .o_result     (w_result),
        .o_state      (w_state_nxt),
        .o_layer      (w_layer_nxt),
        .o_ok         (w_ok)
    );

    // Packing state: commit on every placed item, hold on a size error so
    // that a rejected item leaves no trace
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.free_slots <= FREE_W'(1);
            r_state.prev_log2  <= LAYER_LOG2_RST;
            r_layer            <= '0;
        end else if (w_move && w_ok) begin
            r_state <= w_state_nxt;
            r_layer <= w_layer_nxt;
        end
    end

    // Result register: load on advance, drop after the downstream transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_move) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_result <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_offset_x    = r_result.offset_x;
    assign o_offset_y    = r_result.offset_y;
    assign o_layer_index = r_result.layer_index;
    assign o_size_error  = r_result.size_error;

endmodule

// File: rtl/pow2ap_checker.sv
// ----------------------------------------------------------------------------
// pow2ap_checker
// Port-level checks for the atlas packer, bound to the top level.
// ----------------------------------------------------------------------------
module pow2ap_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [pow2ap_pkg::OFS_W-1:0]  o_offset_x,
    input logic [pow2ap_pkg::OFS_W-1:0]  o_offset_y,
    input logic [pow2ap_pkg::LIDX_W-1:0] o_layer_index,
    input logic                          o_size_error
);
    import pow2ap_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_offset_x) && $stable(o_offset_y)
            && $stable(o_layer_index) && $stable(o_size_error)))
        else $error("stalled result changed");

    // A rejected size carries no placement
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_size_error) |->
            (o_offset_x == '0 && o_offset_y == '0 && o_layer_index == '0))
        else $error("size error with non-zero placement");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // With the result register empty the input stage can always advance
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

endmodule

bind pow2_atlas_array_packer pow2ap_checker u_pow2ap_checker (.*);

// File: test/tb_pow2_atlas_array_packer.sv
// ----------------------------------------------------------------------------
// tb_pow2_atlas_array_packer
// Self-checking bench: a queue-fed driver offers texture sizes, a clocked
// monitor predicts each placement and checks it against the result stream.
// ----------------------------------------------------------------------------
module tb_pow2_atlas_array_packer;

    import pow2ap_pkg::*;

    localparam int unsigned    LAYER_LOG2_CAP = 15;
    localparam int unsigned    LAYER_IDX_BITS = 16;
    localparam logic [15:0]    LAYER_IDX_TOP  = 16'hFFFF;
    localparam int unsigned    WATCHDOG_LIMIT = 3000;
    localparam int unsigned    HOLD_AT        = 400;
    localparam int unsigned    HOLD_CYCLES    = 300;
    localparam int unsigned    PHASE_ITEMS    = 150;
    localparam int unsigned    ROLL_ITEMS     = 24;

    // DUT-facing signals, the inputs known from time zero
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_stall;
    logic [SIZE_W-1:0]     i_size_log2  = '0;
    logic                  i_first_item = 1'b0;
    logic                  o_valid;
    logic                  i_stall      = 1'b0;
    logic [OFS_W-1:0]      o_offset_x;
    logic [OFS_W-1:0]      o_offset_y;
    logic [LIDX_W-1:0]     o_layer_index;
    logic                  o_size_error;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [SIZE_W-1:0]     i_cfg_data   = '0;

    // Packing state as the bench sees it
    logic [SIZE_W-1:0]     layer_log2;
    logic [LIDX_W-1:0]     pk_layer;
    logic [FREE_W-1:0]     pk_free;
    logic [SIZE_W-1:0]     pk_prev;

    t_item                 pending_q[$];    // sizes still to be offered
    t_result               placement_q[$];  // placements still to arrive
    t_result               pred_r;
    t_result               want_r;
    t_result               got_r;

    logic                  item_taken     = 1'b0;
    logic                  moved;
    int unsigned           quiet_cycles   = 0;
    int unsigned           results_seen   = 0;
    int unsigned           fail_cnt       = 0;
    int unsigned           send_gap_pct   = 0;
    int unsigned           recv_stall_pct = 0;
    int unsigned           hold_left      = 0;
    logic                  hold_done      = 1'b0;

    pow2_atlas_array_packer #(
        .MAX_LAYER_LOG2    (LAYER_LOG2_CAP),
        .LAYER_INDEX_WIDTH (LAYER_IDX_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_size_log2   (i_size_log2),
        .i_first_item  (i_first_item),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_offset_x    (o_offset_x),
        .o_offset_y    (o_offset_y),
        .o_layer_index (o_layer_index),
        .o_size_error  (o_size_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Placement predictor. Restart the batch or open a new layer first, then
    // reject oversized textures without touching the state. Otherwise grow the
    // free count by a factor of 4 per level of size drop, take the slot index and split
    // its even and odd bits into x and y.
    // ------------------------------------------------------------------------
    task automatic place_texture(input t_item it, output t_result r);
        logic [SIZE_W-1:0] lsz;
        logic [LIDX_W-1:0] layer;
        logic [FREE_W-1:0] free_cnt;
        logic [SIZE_W-1:0] prev;
        logic [63:0]       grown;
        logic [31:0]       span;
        logic [31:0]       slot;
        logic [31:0]       ox;
        logic [31:0]       oy;
        int unsigned       depth;
        int unsigned       j;
        lsz      = (layer_log2 > LAYER_LOG2_CAP) ? SIZE_W'(LAYER_LOG2_CAP) : layer_log2;
        layer    = pk_layer;
        free_cnt = pk_free;
        prev     = pk_prev;
        r        = '0;
        if (it.first_item) begin
            layer    = '0;
            free_cnt = FREE_W'(1);
            prev     = lsz;
        end
        if (free_cnt == '0) begin
            if (layer != LAYER_IDX_TOP) begin
                layer = layer + 1'b1;
            end
            free_cnt = FREE_W'(1);
            prev     = lsz;
        end
        if (it.size_log2 > prev || it.size_log2 > lsz) begin
            r.size_error = 1'b1;
        end else begin
            grown    = 64'(free_cnt) << (2 * (prev - it.size_log2));
            free_cnt = grown[FREE_W-1:0];
            depth    = lsz - it.size_log2;
            span     = 32'd1 << (2 * depth);
            slot     = (span - 32'(free_cnt)) & (span - 32'd1);
            ox       = '0;
            oy       = '0;
            for (j = 0; j < depth; j++) begin
                ox[j] = slot[2*j];
                oy[j] = slot[2*j+1];
            end
            ox            = ox << it.size_log2;
            oy            = oy << it.size_log2;
            r.offset_x    = ox[OFS_W-1:0];
            r.offset_y    = oy[OFS_W-1:0];
            r.layer_index = layer;
            pk_layer      = layer;
            pk_free       = free_cnt - 1'b1;
            pk_prev       = it.size_log2;
        end
    endtask

    task automatic log_failure(input string what, input t_result want, input t_result got);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display({"%s: expected x=%0d y=%0d layer=%0d err=%0b,",
                      " got x=%0d y=%0d layer=%0d err=%0b"},
                     what, want.offset_x, want.offset_y, want.layer_index, want.size_error,
                     got.offset_x, got.offset_y, got.layer_index, got.size_error);
        end
    endtask

    task automatic queue_item(input logic [SIZE_W-1:0] s, input logic f);
        t_item it;
        it.size_log2  = s;
        it.first_item = f;
        pending_q.push_back(it);
    endtask

    // Mostly sorted batches with random content; some batches carry no start
    // flag, a few items step the size back up, the rest is plain noise.
    task automatic queue_batches(input int unsigned count, input logic [SIZE_W-1:0] lsz);
        int unsigned       made;
        int unsigned       blen;
        int unsigned       drop;
        int unsigned       j;
        logic [SIZE_W-1:0] s;
        logic              start;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_item(SIZE_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                made++;
            end else begin
                blen  = $urandom_range(1, 24);
                s     = SIZE_W'($urandom_range(0, lsz));
                start = ($urandom_range(0, 99) < 85);
                for (j = 0; j < blen; j++) begin
                    if (s != 4'd15 && $urandom_range(0, 99) < 4) begin
                        queue_item(s + 4'd1, 1'b0);
                        made++;
                    end
                    queue_item(s, start && (j == 0));
                    made++;
                    if (s != 4'd0 && $urandom_range(0, 99) < 35) begin
                        drop = $urandom_range(1, (s < 3) ? s : 3);
                        s    = s - SIZE_W'(drop);
                    end
                end
            end
        end
    endtask

    // Wait until every offered size has been placed and checked, then let the
    // pipeline settle before touching the register.
    task automatic drain_all;
        while (pending_q.size() != 0 || placement_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_layer_log2(input logic [SIZE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: record register writes, predict on every input transfer and
    // check every output transfer against the oldest outstanding placement.
    // Input transfers are handled first so a prediction is always in place.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        moved = 1'b0;
        if (!i_rst_n) begin
            layer_log2 = LAYER_LOG2_RST;
            pk_layer   = '0;
            pk_free    = FREE_W'(1);
            pk_prev    = LAYER_LOG2_RST;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                layer_log2 = i_cfg_data;
                moved      = 1'b1;
            end
            if (i_valid && !o_stall) begin
                place_texture({i_size_log2, i_first_item}, pred_r);
                placement_q.push_back(pred_r);
                void'(pending_q.pop_front());
                item_taken = 1'b1;
                moved      = 1'b1;
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                moved = 1'b1;
                got_r = {o_offset_x, o_offset_y, o_layer_index, o_size_error};
                if (placement_q.size() == 0) begin
                    log_failure("unexpected placement", '0, got_r);
                end else begin
                    want_r = placement_q.pop_front();
                    if (got_r.offset_x !== want_r.offset_x
                        || got_r.offset_y !== want_r.offset_y
                        || got_r.layer_index !== want_r.layer_index
                        || got_r.size_error !== want_r.size_error) begin
                        log_failure("placement mismatch", want_r, got_r);
                    end
                end
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    // Driver: hold an offered size until its transfer, then advance to the
    // next queued one or go idle at the current gap rate.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !item_taken) begin
            // hold: stalled payload stays put
        end else begin
            item_taken = 1'b0;
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                i_valid      <= 1'b1;
                i_size_log2  <= pending_q[0].size_log2;
                i_first_item <= pending_q[0].first_item;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once enough results
    // have arrived so that the block fills and pushes back on its input.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: drop out if no transfer of any kind happens for too long.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[pow2_atlas_array_packer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned       p;
        int unsigned       k;
        logic [SIZE_W-1:0] lsz;

        send_gap_pct   = 27;
        recv_stall_pct = 57;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset layer size: pack with no batch start, then open a new layer
        queue_item(4'd7, 1'b0);
        queue_item(4'd5, 1'b0);
        queue_item(4'd5, 1'b0);
        queue_item(4'd6, 1'b0);   // larger than the previous size
        queue_item(4'd8, 1'b0);   // larger than the layer
        queue_item(4'd4, 1'b0);
        queue_item(4'd15, 1'b1);  // rejected, so the batch start is dropped too
        queue_item(4'd0, 1'b0);
        queue_item(4'd0, 1'b1);
        queue_item(4'd0, 1'b0);
        queue_item(4'd7, 1'b1);   // whole layer, so the next ones roll over
        queue_item(4'd7, 1'b0);
        queue_item(4'd3, 1'b1);
        queue_item(4'd2, 1'b0);
        queue_item(4'd1, 1'b0);
        drain_all();

        // Largest layer: deepest slot indices
        write_layer_log2(4'd15);
        queue_item(4'd15, 1'b1);
        queue_item(4'd15, 1'b0);
        queue_item(4'd14, 1'b1);
        queue_item(4'd0, 1'b0);
        queue_item(4'd15, 1'b0);
        drain_all();

        // Smallest layer, changed mid-batch: free count wraps until a restart
        write_layer_log2(4'd0);
        queue_item(4'd0, 1'b0);
        queue_item(4'd1, 1'b1);
        queue_item(4'd0, 1'b1);
        queue_item(4'd0, 1'b0);
        drain_all();

        for (p = 0; p < 12; p++) begin
            if (p < 4) begin
                send_gap_pct   = 27;
                recv_stall_pct = 57;
            end else if (p < 8) begin
                send_gap_pct   = 57;
                recv_stall_pct = 27;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            case (p % 4)
                0:       lsz = 4'd15;
                1:       lsz = 4'd0;
                default: lsz = SIZE_W'($urandom_range(1, 14));
            endcase
            write_layer_log2(lsz);
            queue_batches(PHASE_ITEMS, lsz);
            drain_all();
        end

        // One texel layers: every accepted texture opens a new layer
        write_layer_log2(4'd0);
        queue_item(4'd0, 1'b1);
        for (k = 1; k < ROLL_ITEMS; k++) begin
            queue_item(4'd0, 1'b0);
        end
        queue_item(4'd1, 1'b0);
        drain_all();
        repeat (8) @(posedge i_clk);

        if (fail_cnt == 0 && placement_q.size() == 0) begin
            $display("[pow2_atlas_array_packer] OK");
        end else begin
            $display("[pow2_atlas_array_packer] ERROR");
        end
        $finish;
    end

endmodule
